// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/mpo_pkg.sv =====
package mpo_pkg;

  // Field widths
  localparam int OP_BITS     = 3;
  localparam int FREQ_BITS   = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 40;

  // Oscillator geometry
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int QUARTER_LEN     = 1 << QUARTER_BITS;

  // Step = (frequency * gain) >> STEP_SHIFT, kept to PHASE_BITS
  localparam int STEP_SHIFT = 56 - PHASE_BITS;
  localparam int PROD_BITS  = STEP_SHIFT + PHASE_BITS;
  localparam int GAIN_SPLIT = 20;
  localparam int PART_BITS  = FREQ_BITS + GAIN_SPLIT + 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 40'd5864062015;
  localparam logic [31:0]          NOISE_SEED = 32'd123456789;
  localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]          Q30_ONE = 64'd1 << 30;

  // Waveform selector codes
  localparam logic [OP_BITS-1:0] OP_SINE   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PHASOR = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SAW    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_RECT   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_NOISE  = 3'd4;

  // Classified request passed from front to back
  typedef struct packed {
    logic [OP_BITS-1:0]    wave;
    logic                  adv_phase;
    logic                  adv_noise;
    logic [PHASE_BITS-1:0] step;
  } req_t;

  // Quarter-wave table, entry i holds sin for point i+1 (point 0 is zero)
  typedef logic [QUARTER_LEN-1:0][SAMPLE_BITS-1:0] sine_tab_t;

  // Taylor series to x^11 in Q30, rounded to Q15, saturated
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    for (int i = 1; i <= QUARTER_LEN; i++) begin
      x  = (64'(i) * HALF_PI_Q30) >> QUARTER_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[i-1] = q[SAMPLE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== hw/rtl/mpo_front.sv =====
`include "assert_macros.svh"

module mpo_front
  import mpo_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_BITS-1:0]          op,
  input  logic signed [FREQ_BITS-1:0] frequency,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [GAIN_BITS-1:0]        phase_gain,
  output logic                        push,
  output req_t                        push_req,
  input  logic                        q_full
);

  logic                 gain;
  logic [GAIN_BITS-1:0] gain_reg;

  logic                        f1_valid;
  logic [OP_BITS-1:0]          f1_wave;
  logic                        f1_adv_phase;
  logic                        f1_adv_noise;
  logic signed [PART_BITS-1:0] f1_part_lo;
  logic signed [PART_BITS-1:0] f1_part_hi;

  logic f2_valid;
  req_t f2_req;

  logic f1_move;
  logic f2_free;
  logic in_accept;
  logic signed [PROD_BITS-1:0] prod_sum;

  // Gain register, always ready for a write
  assign cfg_ready = 1'b1;
  assign gain      = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_reg <= GAIN_RESET;
    end else if (gain) begin
      gain_reg <= phase_gain;
    end
  end

  // Pipeline flow control
  assign push      = f2_valid && !q_full;
  assign f2_free   = !f2_valid || push;
  assign f1_move   = f1_valid && f2_free;
  assign in_stall  = f1_valid && !f1_move;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        f1_valid <= in_valid;
      end
      if (f2_free) begin
        f2_valid <= f1_valid;
      end
    end
  end

  // Stage 1: classify and form the two partial products
  always_ff @(posedge clk) begin
    if (in_accept) begin
      f1_wave      <= op;
      f1_adv_phase <= (op == OP_SINE) || (op == OP_PHASOR) ||
                      (op == OP_SAW) || (op == OP_RECT);
      f1_adv_noise <= (op == OP_NOISE);
      f1_part_lo   <= frequency * $signed({1'b0, gain_reg[GAIN_SPLIT-1:0]});
      f1_part_hi   <= frequency * $signed({1'b0, gain_reg[GAIN_BITS-1:GAIN_SPLIT]});
    end
  end

  // Stage 2: combine partials, arithmetic shift gives the phase step
  assign prod_sum = PROD_BITS'(f1_part_lo) + (PROD_BITS'(f1_part_hi) <<< GAIN_SPLIT);

  always_ff @(posedge clk) begin
    if (f1_move) begin
      f2_req.wave      <= f1_wave;
      f2_req.adv_phase <= f1_adv_phase;
      f2_req.adv_noise <= f1_adv_noise;
      f2_req.step      <= prod_sum[PROD_BITS-1 -: PHASE_BITS];
    end
  end

  assign push_req = f2_req;

  `ASSERT_ALWAYS(a_accept_fills_f1, (in_accept |=> f1_valid), "accepted request lost in front")

endmodule

// ===== hw/rtl/mpo_queue.sv =====
`include "assert_macros.svh"

module mpo_queue
  import mpo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output req_t pop_req
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  req_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = (count == CNT_BITS'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign pop_req = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop && !q_valid, "pop from empty queue")

endmodule

// ===== hw/rtl/mpo_back.sv =====
`include "assert_macros.svh"

module mpo_back
  import mpo_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  req_t                          pop_req,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  logic                  b1_valid;
  logic [OP_BITS-1:0]    b1_wave;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [31:0]           noise_word;

  logic b2_free;
  logic b1_move;
  logic b1_free;

  logic [31:0] nz1;
  logic [31:0] nz2;
  logic [31:0] noise_next;

  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [1:0]                   quad;
  logic [QUARTER_BITS-1:0]      k;
  logic [SAMPLE_BITS-1:0]       mag;
  logic signed [SAMPLE_BITS-1:0] sine_val;
  logic signed [SAMPLE_BITS-1:0] wave_sample;

  // Flow control: output register, then state stage
  assign b2_free = !out_valid || !out_stall;
  assign b1_move = b1_valid && b2_free;
  assign b1_free = !b1_valid || b1_move;
  assign pop     = q_valid && b1_free;

  // xorshift32 advance
  assign nz1        = noise_word ^ (noise_word << 13);
  assign nz2        = nz1 ^ (nz1 >> 17);
  assign noise_next = nz2 ^ (nz2 << 5);

  // Oscillator state and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      phase_acc  <= '0;
      noise_word <= NOISE_SEED;
    end else begin
      if (b1_free) begin
        b1_valid <= q_valid;
      end
      if (b2_free) begin
        out_valid <= b1_valid;
      end
      if (pop && pop_req.adv_phase) begin
        phase_acc <= phase_acc + pop_req.step;
      end
      if (pop && pop_req.adv_noise) begin
        noise_word <= noise_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_wave <= pop_req.wave;
    end
  end

  // Quarter-wave sine lookup with mirroring and sign
  assign idx  = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign k    = idx[QUARTER_BITS-1:0];

  always_comb begin
    if (quad[0]) begin
      mag = SINE_TAB[~k];
    end else if (k == '0) begin
      mag = '0;
    end else begin
      mag = SINE_TAB[k - QUARTER_BITS'(1)];
    end
    sine_val = quad[1] ? -$signed(mag) : $signed(mag);
  end

  // Waveform select
  always_comb begin
    unique case (b1_wave)
      OP_SINE:   wave_sample = sine_val;
      OP_PHASOR: wave_sample = $signed({1'b0, phase_acc[PHASE_BITS-1 -: SAMPLE_BITS-1]});
      OP_SAW:    wave_sample = $signed({~phase_acc[PHASE_BITS-1],
                                        phase_acc[PHASE_BITS-2 -: SAMPLE_BITS-1]});
      OP_RECT:   wave_sample = (phase_acc[PHASE_BITS-1] && (|phase_acc[PHASE_BITS-2:0])) ?
                               16'sh7FFF : 16'sh8000;
      OP_NOISE:  wave_sample = $signed({~noise_word[31], noise_word[30:16]});
      default:   wave_sample = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      sample <= wave_sample;
    end
  end

  `ASSERT_ALWAYS(a_phase_hold, (!(pop && pop_req.adv_phase) |=> $stable(phase_acc)), "phase moved without request")
  `ASSERT_ALWAYS(a_noise_hold, (!(pop && pop_req.adv_noise) |=> $stable(noise_word)), "noise moved without request")

endmodule

// ===== hw/rtl/multiwave_phase_oscillator.sv =====
// Channel  Handshake            Payload
// in       in_valid / in_stall  op[2:0], frequency[23:0] signed
// out      out_valid/out_stall  sample[15:0] signed
// cfg      cfg_valid/cfg_ready  phase_gain[39:0]
//
// Sustains one request per cycle while out_stall is low; an output stall holds the flow.
// A request passes through two multiply stages, the queue, the state stage and the output register.
// Reset (rst) is synchronous; no clearing pass.
// An output stall backs up through the back stages and the four-entry queue before in_stall rises.
// cfg_ready is always high; the gain is used by requests accepted after the write.
module multiwave_phase_oscillator
  import mpo_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OP_BITS-1:0]            op,
  input  logic signed [FREQ_BITS-1:0]   frequency,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [GAIN_BITS-1:0]          phase_gain
);

  logic push;
  req_t push_req;
  logic q_full;
  logic pop;
  logic q_valid;
  req_t pop_req;

  // Front: accept, classify, compute phase step
  mpo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .frequency (frequency),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .phase_gain(phase_gain),
    .push      (push),
    .push_req  (push_req),
    .q_full    (q_full)
  );

  // Decoupling queue
  mpo_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_req(push_req),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .pop_req (pop_req)
  );

  // Back: state update and waveform generation
  mpo_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .pop_req  (pop_req),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample   (sample)
  );

endmodule
